### rtl/rcpw_pkg.sv
// Shared types and constants for the RC pulse width capture block.
// No dependencies; every other file imports this package.
package rcpw_pkg;

    localparam int SLOTS = 8;
    localparam int SLOT_W = 3;
    localparam int TS_W = 16;
    localparam int WIN_W = 13;
    localparam int VAL_W = 12;
    localparam int MAP_W = SLOTS * SLOT_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = MAP_W;

    localparam logic [WIN_W-1:0] WINDOW_LOW_RST = 13'd1600;
    localparam logic [WIN_W-1:0] WINDOW_HIGH_RST = 13'd4400;
    localparam logic [VAL_W-1:0] CLAMP_MIN_RST = 12'd900;
    localparam logic [VAL_W-1:0] CLAMP_MAX_RST = 12'd2100;
    localparam logic [MAP_W-1:0] CHANNEL_MAP_RST = 24'd16434705;
    localparam logic [VAL_W-1:0] WIDTH_SLOT0_RST = 12'd900;
    localparam logic [VAL_W-1:0] WIDTH_OTHER_RST = 12'd1500;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_PPM_SUM_MODE = 3'd0,
        REG_WINDOW_LOW   = 3'd1,
        REG_WINDOW_HIGH  = 3'd2,
        REG_CLAMP_MIN    = 3'd3,
        REG_CLAMP_MAX    = 3'd4,
        REG_CHANNEL_MAP  = 3'd5
    } cfg_index_t;

    typedef struct packed
    {
        logic              ppm_sum_mode;
        logic [WIN_W-1:0]  window_low;
        logic [WIN_W-1:0]  window_high;
        logic [VAL_W-1:0]  clamp_min;
        logic [VAL_W-1:0]  clamp_max;
        logic [MAP_W-1:0]  channel_map;
    } cfg_t;

    typedef struct packed
    {
        op_t               op;
        logic [TS_W-1:0]   timestamp;
        logic [SLOTS-1:0]  pins;
        logic [SLOT_W-1:0] channel;
    } item_t;

endpackage

### rtl/rc_pulse_width_capture.sv
// RC pulse width capture: eight-channel receiver decoder.
// Usage:
//   s_* channel carries events: tuser is the op (0 pin sample, 1 read),
//   tdata holds timestamp, pin levels and logical channel. A sample event
//   gives no result; a read event gives one clamped channel value on m_*.
//   cfg_* channel writes the six control registers (index, data); it is
//   always ready and must only be used while the block is idle.
// Timing:
//   An accepted event lands in the input register and is processed from there
//   against the current capture state; a read result then enters the output
//   register, which drives m_tvalid. One event per cycle is accepted while no
//   read result is stalled; a read sees every earlier sample.
// Stall:
//   While a read result waits on m_tready low, a following read holds in
//   the input register and s_tready drops; samples ahead of it keep flowing.
// Reset:
//   rst_n clears pin history, rise times and the PPM slot, loads default
//   stored widths (900 for slot 0, 1500 elsewhere) and register defaults.
// Depends on rcpw_pkg, rcpw_cfg and rcpw_decode.
module rc_pulse_width_capture
    import rcpw_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // timestamp[15:0], pins[23:16], channel[26:24]
    input  logic                  s_tuser,   // op[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // channel_value[11:0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t             cfg;
    item_t            item_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg;
    logic [VAL_W-1:0] rd_value;
    logic             go;
    logic             s_fire;

    assign cfg_ready = 1'b1;

    rcpw_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Samples never need the output slot; reads wait for it
    assign go = in_valid_reg && ((item_reg.op == OP_SAMPLE) || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || go;
    assign s_fire = s_tvalid && s_tready;

    rcpw_decode #(.CHANNELS(CHANNELS)) u_decode
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .item     (item_reg),
        .cfg      (cfg),
        .rd_value (rd_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (go)
            begin
                in_valid_reg <= 1'b0;
            end
            if (go && (item_reg.op == OP_READ))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.op <= op_t'(s_tuser);
            item_reg.timestamp <= s_tdata[15:0];
            item_reg.pins <= s_tdata[23:16];
            item_reg.channel <= s_tdata[26:24];
        end
        if (go && (item_reg.op == OP_READ))
        begin
            out_value_reg <= rd_value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {4'b0000, out_value_reg};

endmodule

### rtl/rcpw_cfg.sv
// Configuration register file for the RC pulse width capture block.
// Depends on rcpw_pkg for register indexes and the cfg_t bundle.
module rcpw_cfg
    import rcpw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_PPM_SUM_MODE: cfg_next.ppm_sum_mode = wr_data[0];
                REG_WINDOW_LOW:   cfg_next.window_low = wr_data[WIN_W-1:0];
                REG_WINDOW_HIGH:  cfg_next.window_high = wr_data[WIN_W-1:0];
                REG_CLAMP_MIN:    cfg_next.clamp_min = wr_data[VAL_W-1:0];
                REG_CLAMP_MAX:    cfg_next.clamp_max = wr_data[VAL_W-1:0];
                REG_CHANNEL_MAP:  cfg_next.channel_map = wr_data[MAP_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ppm_sum_mode <= 1'b0;
            cfg_reg.window_low <= WINDOW_LOW_RST;
            cfg_reg.window_high <= WINDOW_HIGH_RST;
            cfg_reg.clamp_min <= CLAMP_MIN_RST;
            cfg_reg.clamp_max <= CLAMP_MAX_RST;
            cfg_reg.channel_map <= CHANNEL_MAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/rcpw_decode.sv
// Pulse capture state and channel read path: edge detect, width measure,
// PPM slot counter, stored widths and the clamped read value. Uses rcpw_pkg.
module rcpw_decode
    import rcpw_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  item_t            item,
    input  cfg_t             cfg,
    output logic [VAL_W-1:0] rd_value
);

    localparam logic [SLOT_W:0] CHAN_COUNT = (SLOT_W + 1)'(CHANNELS);

    logic [SLOTS-1:0]    previous_pins_reg;
    logic [TS_W-1:0]     rise_times_reg [CHANNELS];
    logic [VAL_W-1:0]    pulse_widths_reg [SLOTS];
    logic [VAL_W-1:0]    pulse_widths_next [SLOTS];
    logic [SLOT_W-1:0]   ppm_slot_reg;
    logic [SLOT_W-1:0]   ppm_slot_next;
    logic [TS_W-1:0]     ppm_rise_time_reg;

    logic                sample;
    logic [SLOTS-1:0]    changed;
    logic [SLOTS-1:0]    split_wr;
    logic [TS_W-1:0]     split_width [CHANNELS];
    logic [TS_W-1:0]     ppm_width;
    logic                ppm_fall;
    logic                ppm_short;
    logic [SLOT_W:0]     slot_inc;
    logic [SLOT_W-1:0]   rd_slot;
    logic [VAL_W-1:0]    rd_raw;

    assign sample = go && (item.op == OP_SAMPLE);
    assign changed = item.pins ^ previous_pins_reg;

    // Split mode: one width measurement per pin
    always_comb
    begin
        split_wr = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            split_width[i] = item.timestamp - rise_times_reg[i];
            split_wr[i] = sample && !cfg.ppm_sum_mode && changed[i] && !item.pins[i]
                          && (split_width[i] > TS_W'(cfg.window_low))
                          && (split_width[i] < TS_W'(cfg.window_high));
        end
    end

    // PPM mode: pin 0 only
    assign ppm_width = item.timestamp - ppm_rise_time_reg;
    assign ppm_fall = sample && cfg.ppm_sum_mode && changed[0] && !item.pins[0];
    assign ppm_short = ppm_width < TS_W'(cfg.window_high);
    assign slot_inc = {1'b0, ppm_slot_reg} + 1'b1;

    always_comb
    begin
        ppm_slot_next = ppm_slot_reg;
        if (ppm_fall)
        begin
            if (ppm_short && (slot_inc < CHAN_COUNT))
            begin
                ppm_slot_next = slot_inc[SLOT_W-1:0];
            end
            else
            begin
                ppm_slot_next = '0;
            end
        end
    end

    // Width below the window top fits in 13 bits, so half of it fits in 12
    always_comb
    begin
        for (int j = 0; j < SLOTS; j++)
        begin
            pulse_widths_next[j] = pulse_widths_reg[j];
            if (ppm_fall && ppm_short && (ppm_slot_reg == SLOT_W'(j)))
            begin
                pulse_widths_next[j] = ppm_width[VAL_W:1];
            end
        end
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (split_wr[i])
            begin
                pulse_widths_next[i] = split_width[i][VAL_W:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_pins_reg <= '0;
            ppm_slot_reg <= '0;
            ppm_rise_time_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                rise_times_reg[i] <= '0;
            end
            for (int j = 0; j < SLOTS; j++)
            begin
                pulse_widths_reg[j] <= (j == 0) ? WIDTH_SLOT0_RST : WIDTH_OTHER_RST;
            end
        end
        else
        begin
            ppm_slot_reg <= ppm_slot_next;
            for (int j = 0; j < SLOTS; j++)
            begin
                pulse_widths_reg[j] <= pulse_widths_next[j];
            end
            if (sample)
            begin
                previous_pins_reg <= item.pins;
                if (cfg.ppm_sum_mode && changed[0] && item.pins[0])
                begin
                    ppm_rise_time_reg <= item.timestamp;
                end
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (!cfg.ppm_sum_mode && changed[i] && item.pins[i])
                    begin
                        rise_times_reg[i] <= item.timestamp;
                    end
                end
            end
        end
    end

    // Read path: remap logical channel, then clamp
    always_comb
    begin
        rd_slot = cfg.channel_map[SLOT_W*item.channel +: SLOT_W];
        rd_raw = pulse_widths_reg[rd_slot];
        priority if (rd_raw < cfg.clamp_min)
        begin
            rd_value = cfg.clamp_min;
        end
        else if (rd_raw > cfg.clamp_max)
        begin
            rd_value = cfg.clamp_max;
        end
        else
        begin
            rd_value = rd_raw;
        end
    end

endmodule
